// ----- rtl/slwap_pkg.sv -----
// ----------------------------------------------------------------------------
// slwap_pkg
// Shared types, constants and helpers for the sound level window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package slwap_pkg;

    localparam int LEVEL_W          = 11;
    localparam int OPCODE_W         = 2;
    localparam int HELD_W           = 5;
    localparam int BAND_W           = 3;
    localparam int WINDOW_DEPTH_DEF = 16;

    localparam logic [OPCODE_W-1:0] OP_PUSH     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLR_PEAK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART  = 2'd2;

    localparam logic [LEVEL_W-1:0] TH_WHITE  = 11'd900;
    localparam logic [LEVEL_W-1:0] TH_RED    = 11'd800;
    localparam logic [LEVEL_W-1:0] TH_YELLOW = 11'd700;
    localparam logic [LEVEL_W-1:0] TH_GREEN  = 11'd600;
    localparam logic [LEVEL_W-1:0] TH_LBLUE  = 11'd500;
    localparam logic [LEVEL_W-1:0] TH_BLUE   = 11'd400;
    localparam logic [LEVEL_W-1:0] TH_PURPLE = 11'd350;

    localparam logic [BAND_W-1:0] BAND_OFF    = 3'd0;
    localparam logic [BAND_W-1:0] BAND_PURPLE = 3'd1;
    localparam logic [BAND_W-1:0] BAND_BLUE   = 3'd2;
    localparam logic [BAND_W-1:0] BAND_LBLUE  = 3'd3;
    localparam logic [BAND_W-1:0] BAND_GREEN  = 3'd4;
    localparam logic [BAND_W-1:0] BAND_YELLOW = 3'd5;
    localparam logic [BAND_W-1:0] BAND_RED    = 3'd6;
    localparam logic [BAND_W-1:0] BAND_WHITE  = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LEVEL_W-1:0]  level_tenths;
    } t_in_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] average_tenths;
        logic [LEVEL_W-1:0] peak_tenths;
        logic [HELD_W-1:0]  samples_held;
        logic               led_red;
        logic               led_green;
        logic               led_blue;
    } t_out_resp;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_push;
        logic walk_last;
        logic div_last;
    } t_stat;

    function automatic logic [BAND_W-1:0] band_of(input logic [LEVEL_W-1:0] s);
        logic [BAND_W-1:0] b;
        if (s >= TH_WHITE)       b = BAND_WHITE;
        else if (s >= TH_RED)    b = BAND_RED;
        else if (s >= TH_YELLOW) b = BAND_YELLOW;
        else if (s >= TH_GREEN)  b = BAND_GREEN;
        else if (s >= TH_LBLUE)  b = BAND_LBLUE;
        else if (s >= TH_BLUE)   b = BAND_BLUE;
        else if (s >= TH_PURPLE) b = BAND_PURPLE;
        else                     b = BAND_OFF;
        return b;
    endfunction

    // bit 2 red, bit 1 green, bit 0 blue
    function automatic logic [2:0] rgb_of(input logic [BAND_W-1:0] b);
        logic [2:0] c;
        unique case (b)
            BAND_OFF:    c = 3'b000;
            BAND_PURPLE: c = 3'b101;
            BAND_BLUE:   c = 3'b001;
            BAND_LBLUE:  c = 3'b011;
            BAND_GREEN:  c = 3'b010;
            BAND_YELLOW: c = 3'b110;
            BAND_RED:    c = 3'b100;
            BAND_WHITE:  c = 3'b111;
            default:     c = 3'b000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/slwap_ram.sv -----
// ----------------------------------------------------------------------------
// slwap_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slwap_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/slwap_datapath.sv -----
// ----------------------------------------------------------------------------
// slwap_datapath
// Window store, running sum and peak, serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slwap_datapath #(
    parameter int WINDOW_DEPTH = slwap_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire slwap_pkg::t_in_req  i_in_data,
    input  wire slwap_pkg::t_cmd     i_cmd,
    output slwap_pkg::t_stat         o_stat,
    output slwap_pkg::t_out_resp     o_out_data
);

    import slwap_pkg::*;

    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = LEVEL_W + AW;
    localparam int DCW = $clog2(SW);

    logic [AW-1:0]      r_wr_idx, n_wr_idx;
    logic [CW-1:0]      r_fill, n_fill;
    logic [LEVEL_W-1:0] r_peak, n_peak;
    logic [LEVEL_W-1:0] r_avg, n_avg;
    logic [BAND_W-1:0]  r_color, n_color;
    logic               r_rd_pend;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic [SW-1:0]      r_sum, n_sum;
    logic [CW-1:0]      r_rem, n_rem;
    logic [SW-1:0]      r_quo, n_quo;
    logic [DCW-1:0]     r_dcnt, n_dcnt;
    t_out_resp          r_out, n_out;

    logic               push;
    logic [LEVEL_W-1:0] rdata;
    logic [CW:0]        rem_sh;
    logic [CW-1:0]      rem_diff;
    logic               rem_ge;
    logic [2:0]         rgb;

    assign push = i_cmd.accept && (i_in_data.opcode == OP_PUSH);

    slwap_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr_idx),
        .i_wdata (i_in_data.level_tenths),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    assign rem_sh   = {r_rem, r_quo[SW-1]};
    assign rem_diff = rem_sh[CW-1:0] - r_fill;
    assign rem_ge   = (rem_sh >= {1'b0, r_fill});
    assign rgb      = rgb_of(r_color);

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_fill   = r_fill;
        n_peak   = r_peak;
        n_avg    = r_avg;
        n_color  = r_color;
        n_rd_idx = r_rd_idx;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dcnt   = r_dcnt;
        n_out    = r_out;

        if (i_cmd.accept) begin
            unique case (i_in_data.opcode)
                OP_PUSH: begin
                    n_wr_idx = (r_wr_idx == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
                    n_fill   = (r_fill == CW'(WINDOW_DEPTH)) ? r_fill : r_fill + 1'b1;
                    n_color  = band_of(i_in_data.level_tenths);
                    n_rd_idx = '0;
                    n_sum    = '0;
                end
                OP_CLR_PEAK: begin
                    n_peak = '0;
                end
                OP_RESTART: begin
                    n_wr_idx = '0;
                    n_fill   = '0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.rd_issue) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end

        if (r_rd_pend) begin
            n_sum = r_sum + SW'(rdata);
            if (rdata > r_peak) begin
                n_peak = rdata;
            end
        end

        if (i_cmd.div_init) begin
            n_rem  = '0;
            n_quo  = r_sum;
            n_dcnt = DCW'(SW - 1);
        end else if (i_cmd.div_step) begin
            n_rem  = rem_ge ? rem_diff : rem_sh[CW-1:0];
            n_quo  = {r_quo[SW-2:0], rem_ge};
            n_dcnt = r_dcnt - 1'b1;
            if (r_dcnt == '0) begin
                n_avg = n_quo[LEVEL_W-1:0];
            end
        end

        if (i_cmd.load_out) begin
            n_out.average_tenths = r_avg;
            n_out.peak_tenths    = r_peak;
            n_out.samples_held   = HELD_W'(r_fill);
            n_out.led_red        = rgb[2];
            n_out.led_green      = rgb[1];
            n_out.led_blue       = rgb[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_fill    <= '0;
            r_peak    <= '0;
            r_avg     <= '0;
            r_color   <= BAND_OFF;
            r_rd_pend <= 1'b0;
        end else begin
            r_wr_idx  <= n_wr_idx;
            r_fill    <= n_fill;
            r_peak    <= n_peak;
            r_avg     <= n_avg;
            r_color   <= n_color;
            r_rd_pend <= i_cmd.rd_issue;
        end
        r_rd_idx <= n_rd_idx;
        r_sum    <= n_sum;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dcnt   <= n_dcnt;
        r_out    <= n_out;
    end

    assign o_stat.in_push   = (i_in_data.opcode == OP_PUSH);
    assign o_stat.walk_last = (CW'(r_rd_idx) == r_fill - 1'b1);
    assign o_stat.div_last  = (r_dcnt == '0);
    assign o_out_data       = r_out;

endmodule

`default_nettype wire

// ----- rtl/slwap_ctrl.sv -----
// ----------------------------------------------------------------------------
// slwap_ctrl
// Sequencer: request intake, window walk, divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module slwap_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire slwap_pkg::t_stat i_stat,
    output slwap_pkg::t_cmd       o_cmd
);

    import slwap_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WALK  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_DINIT = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = i_stat.in_push ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                cmd.rd_issue = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// ----- rtl/sound_level_window_average_peak.sv -----
// ----------------------------------------------------------------------------
// sound_level_window_average_peak
// Moving average over a ring window of sound levels, with peak hold and a
// level colour band.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request at a
// time: push a sample, clear the peak or restart the window fill. Output
// channel (o_out_valid / i_out_stall / o_out_data) returns one result per
// request: average, peak, samples held and the three colour channels.
// A push walks the held entries through the window RAM read port, one per
// cycle, then runs a restoring divider one quotient bit per cycle. Other
// opcodes skip the walk and the divide and go straight to the result.
// The result sits in an output register, so a new request is taken while
// the previous result waits on a stalled receiver; a further result then
// holds until that register is free.
// Reset clears the index, fill count, peak, average and colour; the window
// RAM needs no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_level_window_average_peak #(
    parameter int WINDOW_DEPTH = slwap_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire slwap_pkg::t_in_req   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output slwap_pkg::t_out_resp      o_out_data
);

    import slwap_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    slwap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    slwap_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/slwap_checker.sv -----
// ----------------------------------------------------------------------------
// slwap_checker
// Port-level checks on the sound level averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slwap_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire slwap_pkg::t_in_req   i_in_data,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire slwap_pkg::t_out_resp o_out_data
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled request changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one in progress");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sound_level_window_average_peak slwap_checker u_slwap_checker (.*);

`default_nettype wire

// ----- verif/tb_sound_level_window_average_peak.sv -----
// ----------------------------------------------------------------------------
// tb_sound_level_window_average_peak
// Self-checking bench for the sound level window averager. A short table of
// directed requests covers reset values, level extremes, every colour band
// edge, peak clear, fill restart, window wrap and the unused opcode. About
// 1800 random requests follow. Each result is compared field by field with
// values given in the table or with a cycle-free model of the window, peak
// and colour band; both channels idle in random bursts until a quiet tail.
// ----------------------------------------------------------------------------
module tb_sound_level_window_average_peak;

    import slwap_pkg::*;

    localparam int DEPTH        = WINDOW_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_ITEMS   = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    localparam logic [LEVEL_W-1:0] BAND_EDGES [7] = '{
        TH_PURPLE, TH_BLUE, TH_LBLUE, TH_GREEN, TH_YELLOW, TH_RED, TH_WHITE
    };
    localparam logic [LEVEL_W-1:0] LEVEL_EXTREMES [7] = '{
        11'd0, 11'd1, 11'd1499, 11'd1500, 11'd1501, 11'd2046, 11'd2047
    };
    // red, green, blue per band, off up to white
    localparam logic [2:0] BAND_RGB [8] = '{
        3'b000, 3'b101, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b111
    };

    typedef struct {
        t_in_req   req;
        bit        typed;
        t_out_resp resp;
    } t_level_row;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_req   in_req    = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_resp out_resp;

    t_level_row level_rows [$];
    t_out_resp  expected_levels [$];
    int         fail_count  = 0;
    bit         src_idle_on = 1'b1;
    bit         sink_idle_on = 1'b1;
    bit         quiet_tail  = 1'b0;
    int         stall_left  = 0;
    int         sink_cycles = 0;
    int         idle_run    = 0;

    logic [LEVEL_W-1:0] ring [DEPTH];
    int unsigned        ring_wr   = 0;
    int unsigned        ring_fill = 0;
    bit                 ring_full = 1'b0;
    logic [LEVEL_W-1:0] peak_hold = '0;
    logic [LEVEL_W-1:0] avg_hold  = '0;
    logic [BAND_W-1:0]  band_hold = BAND_OFF;

    sound_level_window_average_peak #(
        .WINDOW_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_resp)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [BAND_W-1:0] level_band(input logic [LEVEL_W-1:0] s);
        logic [BAND_W-1:0] b;
        b = '0;
        for (int k = 0; k < 7; k++) begin
            b = b + BAND_W'(s >= BAND_EDGES[k]);
        end
        return b;
    endfunction

    function automatic t_out_resp predict_level(input t_in_req req);
        t_out_resp   r;
        int unsigned sum;
        case (req.opcode)
            OP_PUSH: begin
                ring[ring_wr] = req.level_tenths;
                ring_wr = (ring_wr + 1) % DEPTH;
                if (ring_full || ring_fill + 1 >= DEPTH) begin
                    ring_fill = DEPTH;
                    ring_full = 1'b1;
                end else begin
                    ring_fill = ring_fill + 1;
                end
                sum = 0;
                for (int k = 0; k < ring_fill; k++) begin
                    sum = sum + ring[k];
                    if (ring[k] > peak_hold) peak_hold = ring[k];
                end
                avg_hold  = LEVEL_W'(sum / ring_fill);
                band_hold = level_band(req.level_tenths);
            end
            OP_CLR_PEAK: begin
                peak_hold = '0;
            end
            OP_RESTART: begin
                ring_wr   = 0;
                ring_fill = 0;
                ring_full = 1'b0;
            end
            default: begin
            end
        endcase
        r.average_tenths = avg_hold;
        r.peak_tenths    = peak_hold;
        r.samples_held   = HELD_W'(ring_fill);
        {r.led_red, r.led_green, r.led_blue} = BAND_RGB[band_hold];
        return r;
    endfunction

    function automatic t_in_req random_request();
        t_in_req     r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 84)      r.opcode = OP_PUSH;
        else if (pick < 91) r.opcode = OP_CLR_PEAK;
        else if (pick < 95) r.opcode = OP_RESTART;
        else                r.opcode = OP_NONE;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            r.level_tenths = LEVEL_W'($urandom_range(0, 2047));
        end else if (pick == 2) begin
            r.level_tenths = BAND_EDGES[$urandom_range(0, 6)] + LEVEL_W'($urandom_range(0, 4))
                             - LEVEL_W'(2);
        end else if (pick == 3) begin
            r.level_tenths = LEVEL_EXTREMES[$urandom_range(0, 6)];
        end else begin
            r.level_tenths = LEVEL_W'($urandom_range(250, 1000));
        end
        return r;
    endfunction

    task automatic add_row(input logic [OPCODE_W-1:0] op, input int unsigned lvl,
                           input bit typed, input t_out_resp resp);
        t_level_row row;
        row.req.opcode       = op;
        row.req.level_tenths = LEVEL_W'(lvl);
        row.typed            = typed;
        row.resp             = resp;
        level_rows.push_back(row);
    endtask

    task automatic send_request(input t_in_req req, input bit typed, input t_out_resp resp);
        int        gap;
        t_out_resp predicted;
        gap = 0;
        if (!quiet_tail && src_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (in_stall);
        predicted = predict_level(req);
        expected_levels.push_back(typed ? resp : predicted);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input t_out_resp got);
        t_out_resp want;
        if (expected_levels.size() == 0) begin
            $display("%0t: result expected none actual avg %0d peak %0d held %0d rgb %b%b%b",
                     $time, got.average_tenths, got.peak_tenths, got.samples_held,
                     got.led_red, got.led_green, got.led_blue);
            fail_count++;
        end else begin
            want = expected_levels.pop_front();
            check_field("average_tenths", want.average_tenths, got.average_tenths);
            check_field("peak_tenths", want.peak_tenths, got.peak_tenths);
            check_field("samples_held", want.samples_held, got.samples_held);
            check_field("led_red", want.led_red, got.led_red);
            check_field("led_green", want.led_green, got.led_green);
            check_field("led_blue", want.led_blue, got.led_blue);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) check_result(out_resp);
            if (sink_cycles % 512 == 0) sink_idle_on = $urandom_range(0, 2) != 0;
            sink_cycles++;
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet_tail && sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_run = 0;
            end else if (idle_run >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_run++;
            end
        end
    end

    initial begin
        add_row(OP_NONE,     0,    1'b1, t_out_resp'{11'd0, 11'd0, 5'd0, 1'b0, 1'b0, 1'b0});
        add_row(OP_CLR_PEAK, 0,    1'b1, t_out_resp'{11'd0, 11'd0, 5'd0, 1'b0, 1'b0, 1'b0});
        add_row(OP_RESTART,  0,    1'b1, t_out_resp'{11'd0, 11'd0, 5'd0, 1'b0, 1'b0, 1'b0});
        add_row(OP_PUSH,     2047, 1'b1,
                t_out_resp'{11'd2047, 11'd2047, 5'd1, 1'b1, 1'b1, 1'b1});
        add_row(OP_PUSH,     0,    1'b1,
                t_out_resp'{11'd1023, 11'd2047, 5'd2, 1'b0, 1'b0, 1'b0});
        add_row(OP_CLR_PEAK, 0,    1'b1,
                t_out_resp'{11'd1023, 11'd0, 5'd2, 1'b0, 1'b0, 1'b0});
        add_row(OP_PUSH,     349,  1'b0, '0);
        for (int k = 0; k < 7; k++) add_row(OP_PUSH, BAND_EDGES[k], 1'b0, '0);
        add_row(OP_PUSH,     1500, 1'b0, '0);
        add_row(OP_PUSH,     1,    1'b0, '0);
        add_row(OP_PUSH,     1024, 1'b0, '0);
        add_row(OP_PUSH,     512,  1'b0, '0);
        add_row(OP_PUSH,     1023, 1'b0, '0);
        add_row(OP_PUSH,     2047, 1'b0, '0);
        // wrap onto the oldest entry
        add_row(OP_PUSH,     1500, 1'b0, '0);
        add_row(OP_RESTART,  0,    1'b0, '0);
        add_row(OP_PUSH,     5,    1'b0, '0);
        add_row(OP_NONE,     2047, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (level_rows[k]) send_request(level_rows[k].req, level_rows[k].typed,
                                             level_rows[k].resp);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 128 == 0) src_idle_on = $urandom_range(0, 1);
            if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            send_request(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
